FILE: rtl/conv3_pkg.sv
// Shared constants and register codes of the 3x3 image filter.
`default_nettype none

package conv3_pkg;

	localparam int PIX_W        = 8;
	localparam int MAX_CHANNELS = 3;
	localparam int COL_W        = 11;
	localparam int ROW_W        = 12;
	localparam int CFG_W        = 17;
	localparam int CFG_IDX_W    = 3;
	localparam int IMG_W_W      = 12;
	localparam int IMG_H_W      = 13;
	localparam int MAX_HEIGHT   = 4096;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int DEF_CHANNELS  = 3;

	localparam logic [IMG_W_W-1:0] RST_WIDTH  = IMG_W_W'(640);
	localparam logic [IMG_H_W-1:0] RST_HEIGHT = IMG_H_W'(480);
	localparam logic [CFG_W-1:0]   RST_WEIGHT = CFG_W'(7282);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_WEIGHT_CENTER = 3'd2,
		REG_WEIGHT_EDGE   = 3'd3,
		REG_WEIGHT_CORNER = 3'd4
	} cfg_reg_t;

endpackage

`default_nettype wire

FILE: rtl/conv3_pix_if.sv
// Input pixel channel: valid/ready handshake with frame start and three samples.
`default_nettype none

interface conv3_pix_if import conv3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             frame_start;
	logic [PIX_W-1:0] chan0;
	logic [PIX_W-1:0] chan1;
	logic [PIX_W-1:0] chan2;

	modport source (output valid, frame_start, chan0, chan1, chan2, input ready);
	modport sink   (input valid, frame_start, chan0, chan1, chan2, output ready);
endinterface

`default_nettype wire

FILE: rtl/conv3_res_if.sv
// Result channel: valid/ready handshake with filtered samples and position.
`default_nettype none

interface conv3_res_if import conv3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out0;
	logic [PIX_W-1:0] out1;
	logic [PIX_W-1:0] out2;
	logic [COL_W-1:0] center_col;
	logic [ROW_W-1:0] center_row;
	logic             interior;

	modport source (output valid, out0, out1, out2, center_col, center_row, interior,
		input ready);
	modport sink   (input valid, out0, out1, out2, center_col, center_row, interior,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/conv3_col_cell.sv
// One window column cell: holds three pixels and hands them on when shifted.
`default_nettype none

module conv3_col_cell import conv3_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  shift,
	input  wire logic [2:0][CHANNELS-1:0][PIX_W-1:0] col_in,
	output logic      [2:0][CHANNELS-1:0][PIX_W-1:0] col_out
);

	logic [2:0][CHANNELS-1:0][PIX_W-1:0] col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

`default_nettype wire

FILE: rtl/conv3_chan_flt.sv
// Per-channel symmetric 3x3 kernel: tap sums, weight products, truncate and saturate.
`default_nettype none

module conv3_chan_flt import conv3_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        adv,
	input  wire logic [2:0][2:0][PIX_W-1:0] win,
	input  wire logic [CFG_W-1:0]           weight_center,
	input  wire logic [CFG_W-1:0]           weight_edge,
	input  wire logic [CFG_W-1:0]           weight_corner,
	output logic      [PIX_W-1:0]           q
);

	localparam int SUM4_W = PIX_W + 2;
	localparam int PC_W   = PIX_W + CFG_W;
	localparam int PE_W   = SUM4_W + CFG_W;
	localparam int ACC_W  = PE_W + 2;
	localparam int HI_W   = ACC_W - 16;

	logic [PIX_W-1:0]  ctr_s2;
	logic [SUM4_W-1:0] edg_s2;
	logic [SUM4_W-1:0] cor_s2;
	logic [PC_W-1:0]   pc_s3;
	logic [PE_W-1:0]   pe_s3;
	logic [PE_W-1:0]   pk_s3;
	logic [ACC_W-1:0]  acc;
	logic [HI_W-1:0]   hi;
	logic [PIX_W-1:0]  q_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctr_s2 <= win[1][1];
			edg_s2 <= SUM4_W'(win[0][1]) + SUM4_W'(win[2][1])
				+ SUM4_W'(win[1][0]) + SUM4_W'(win[1][2]);
			cor_s2 <= SUM4_W'(win[0][0]) + SUM4_W'(win[0][2])
				+ SUM4_W'(win[2][0]) + SUM4_W'(win[2][2]);
			pc_s3  <= PC_W'(ctr_s2) * PC_W'(weight_center);
			pe_s3  <= PE_W'(edg_s2) * PE_W'(weight_edge);
			pk_s3  <= PE_W'(cor_s2) * PE_W'(weight_corner);
			q_q    <= (hi > HI_W'(255)) ? PIX_W'(255) : hi[PIX_W-1:0];
		end
	end

	assign acc = ACC_W'(pc_s3) + ACC_W'(pe_s3) + ACC_W'(pk_s3);
	assign hi  = acc[ACC_W-1:16];
	assign q   = q_q;

endmodule

`default_nettype wire

FILE: rtl/conv3x3_image_filter_top.sv
// Top level of the 3x3 image filter: counters, line buffers, window cells, filters.
// Each result passes stage 1, filter stages 2 and 3 and the output register.
// Throughput: one pixel per cycle; the whole pipeline holds while the output stalls.
// Pixels in the first row or first column of a frame give no result.
// Reset clears counters, valid flags, window cells and config registers to defaults;
// line buffer contents stay undefined until written, and no clearing pass runs.
`default_nettype none

module conv3x3_image_filter_top import conv3_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int CHANNELS  = DEF_CHANNELS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	conv3_pix_if.sink                 pix,
	conv3_res_if.source               res,
	input  wire logic                 cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// column index width, and a compare width that holds both MAX_WIDTH and the register
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int MWW = $clog2(MAX_WIDTH + 1);
	localparam int EW  = (MWW > IMG_W_W) ? MWW : IMG_W_W;
	localparam int PW  = CHANNELS * PIX_W;

	typedef logic [2:0][CHANNELS-1:0][PIX_W-1:0] col_t;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	logic [CFG_W-1:0]   wc_q;
	logic [CFG_W-1:0]   we_q;
	logic [CFG_W-1:0]   wk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			wc_q     <= RST_WEIGHT;
			we_q     <= RST_WEIGHT;
			wk_q     <= RST_WEIGHT;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:   width_q  <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg_data[IMG_H_W-1:0];
				REG_WEIGHT_CENTER: wc_q     <= cfg_data;
				REG_WEIGHT_EDGE:   we_q     <= cfg_data;
				REG_WEIGHT_CORNER: wk_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Pipeline advance: every stage moves unless a finished result is
	// still waiting at the output register.
	// ---------------------------------------------------------------
	logic adv;
	logic in_xfer;
	logic out_vld_q;

	assign adv       = !out_vld_q || res.ready;
	assign pix.ready = adv;
	assign in_xfer   = pix.valid && adv;

	// ---------------------------------------------------------------
	// Position counters, clamped to the effective frame size
	// ---------------------------------------------------------------
	logic [EW-1:0]      eff_w;
	logic [EW-1:0]      w_ext;
	logic [IMG_H_W-1:0] eff_h;
	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;
	logic [CW-1:0]      col_cur;
	logic [ROW_W-1:0]   row_cur;
	logic [EW-1:0]      col_inc;
	logic [IMG_H_W-1:0] row_inc;
	logic               line_end;

	always_comb begin
		w_ext = EW'(width_q);
		if (w_ext == '0) begin
			eff_w = EW'(1);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = w_ext;
		end
		if (height_q == '0) begin
			eff_h = IMG_H_W'(1);
		end else if (height_q > IMG_H_W'(MAX_HEIGHT)) begin
			eff_h = IMG_H_W'(MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	// frame start clears both counters; a stale count past a shrunken frame drops to zero
	assign col_cur  = (pix.frame_start || EW'(col_q) >= eff_w) ? '0 : col_q;
	assign row_cur  = (pix.frame_start || IMG_H_W'(row_q) >= eff_h) ? '0 : row_q;
	assign col_inc  = EW'(col_cur) + EW'(1);
	assign row_inc  = IMG_H_W'(row_cur) + IMG_H_W'(1);
	assign line_end = col_inc >= eff_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			col_q <= line_end ? '0 : col_inc[CW-1:0];
			if (line_end) begin
				row_q <= (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				row_q <= row_cur;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: registered line buffer read and the incoming pixel
	// ---------------------------------------------------------------
	logic [CHANNELS-1:0][PIX_W-1:0] pix_w;
	logic [MAX_CHANNELS-1:0][PIX_W-1:0] pix_all;

	assign pix_all = {pix.chan2, pix.chan1, pix.chan0};
	assign pix_w   = pix_all[CHANNELS-1:0];

	// each word packs the line two above (upper half) and the line above (lower half)
	logic [2*PW-1:0] lbuf [MAX_WIDTH];

	logic            vld_s1;
	logic [PW-1:0]   pix_s1;
	logic [CW-1:0]   col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [2*PW-1:0] rd_s1;
	logic            fwd_s1;
	logic [PW-1:0]   fwd_pix_s1;
	logic [PW-1:0]   fwd_mid_s1;
	logic [PW-1:0]   mid_eff;
	logic [PW-1:0]   top_eff;

	// back-to-back pixels at the same column (a one-pixel line) bypass the buffer
	assign mid_eff = fwd_s1 ? fwd_pix_s1 : rd_s1[PW-1:0];
	assign top_eff = fwd_s1 ? fwd_mid_s1 : rd_s1[2*PW-1:PW];

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= lbuf[col_cur];
		end
		if (adv && vld_s1) begin
			lbuf[col_s1] <= {mid_eff, pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix.valid;
			fwd_s1 <= pix.valid && vld_s1 && (col_s1 == col_cur);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1     <= pix_w;
			col_s1     <= col_cur;
			row_s1     <= row_cur;
			fwd_pix_s1 <= pix_s1;
			fwd_mid_s1 <= mid_eff;
		end
	end

	// ---------------------------------------------------------------
	// Window: the right column comes straight from stage 1, the middle
	// and left columns sit in a chain of two cells
	// ---------------------------------------------------------------
	col_t col_right;
	col_t col_mid;
	col_t col_left;
	logic shift;

	assign col_right = {pix_s1, mid_eff, top_eff};
	assign shift     = adv && vld_s1;

	conv3_col_cell #(.CHANNELS(CHANNELS)) u_cell_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (shift),
		.col_in  (col_right),
		.col_out (col_mid)
	);

	conv3_col_cell #(.CHANNELS(CHANNELS)) u_cell_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (shift),
		.col_in  (col_mid),
		.col_out (col_left)
	);

	// ---------------------------------------------------------------
	// Per-channel filters, three stages deep
	// ---------------------------------------------------------------
	logic [MAX_CHANNELS-1:0][PIX_W-1:0] flt_q;

	for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_chan
		if (ch < CHANNELS) begin : g_on
			logic [2:0][2:0][PIX_W-1:0] win;
			for (genvar r = 0; r < 3; r++) begin : g_row
				assign win[r][0] = col_left[r][ch];
				assign win[r][1] = col_mid[r][ch];
				assign win[r][2] = col_right[r][ch];
			end
			conv3_chan_flt u_flt (
				.clk           (clk),
				.adv           (adv),
				.win           (win),
				.weight_center (wc_q),
				.weight_edge   (we_q),
				.weight_corner (wk_q),
				.q             (flt_q[ch])
			);
		end else begin : g_off
			assign flt_q[ch] = '0;
		end
	end

	// ---------------------------------------------------------------
	// Result flags travel alongside the filter stages
	// ---------------------------------------------------------------
	logic             vld_s2, vld_s3;
	logic             inner_s2, inner_s3, inner_q;
	logic [COL_W-1:0] ccol_s2, ccol_s3, ccol_q;
	logic [ROW_W-1:0] crow_s2, crow_s3, crow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s2    <= vld_s1 && (col_s1 != '0) && (row_s1 != '0);
			vld_s3    <= vld_s2;
			out_vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inner_s2 <= (col_s1 >= CW'(2)) && (row_s1 >= ROW_W'(2));
			ccol_s2  <= COL_W'(col_s1 - CW'(1));
			crow_s2  <= row_s1 - ROW_W'(1);
			inner_s3 <= inner_s2;
			ccol_s3  <= ccol_s2;
			crow_s3  <= crow_s2;
			inner_q  <= inner_s3;
			ccol_q   <= ccol_s3;
			crow_q   <= crow_s3;
		end
	end

	// border results carry zero samples
	assign res.valid      = out_vld_q;
	assign res.out0       = inner_q ? flt_q[0] : '0;
	assign res.out1       = inner_q ? flt_q[1] : '0;
	assign res.out2       = inner_q ? flt_q[2] : '0;
	assign res.center_col = ccol_q;
	assign res.center_row = crow_q;
	assign res.interior   = inner_q;

endmodule

`default_nettype wire

FILE: test/tb_conv3x3_image_filter_top.sv
// Self-checking testbench of the 3x3 image filter: pixel stimulus, own prediction, result checks.
`timescale 1ns / 1ps

module tb_conv3x3_image_filter_top;
	import conv3_pkg::*;

	// Limits and timing of the run
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 12;     // lets the pipeline empty after the last awaited result
	localparam int RANDOM_PIXELS = 1300;

	// Q1.16 one, and a register index that the block does not decode
	localparam logic [CFG_W-1:0]     UNITY_WEIGHT = CFG_W'(65536);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE    = CFG_IDX_W'(7);

	typedef struct packed {
		logic [MAX_CHANNELS-1:0][PIX_W-1:0] outs;
		logic [COL_W-1:0]                   col;
		logic [ROW_W-1:0]                   row;
		logic                               interior;
	} filt_res_t;

	// Scoreboard: carries its own copy of the registers, line stores and window,
	// works out the result of each pixel past the first row and column, checks results in order.
	class filter_scoreboard;
		logic [IMG_W_W-1:0] width_reg;
		logic [IMG_H_W-1:0] height_reg;
		logic [CFG_W-1:0]   wt_center;
		logic [CFG_W-1:0]   wt_side;
		logic [CFG_W-1:0]   wt_diag;
		logic [23:0]        prev_line [DEF_MAX_WIDTH];
		logic [23:0]        prev_prev_line [DEF_MAX_WIDTH];
		logic [23:0]        win_cells [6];
		int unsigned        col_pos;
		int unsigned        row_pos;
		filt_res_t          expected_q [$];
		int unsigned        mismatches;
		int unsigned        results_seen;
		int unsigned        interior_seen;

		function new();
			width_reg     = RST_WIDTH;
			height_reg    = RST_HEIGHT;
			wt_center     = RST_WEIGHT;
			wt_side       = RST_WEIGHT;
			wt_diag       = RST_WEIGHT;
			foreach (win_cells[i]) win_cells[i] = '0;
			col_pos       = 0;
			row_pos       = 0;
			mismatches    = 0;
			results_seen  = 0;
			interior_seen = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
			REG_IMAGE_WIDTH:   width_reg  = val[IMG_W_W-1:0];
			REG_IMAGE_HEIGHT:  height_reg = val[IMG_H_W-1:0];
			REG_WEIGHT_CENTER: wt_center  = val;
			REG_WEIGHT_EDGE:   wt_side    = val;
			REG_WEIGHT_CORNER: wt_diag    = val;
			default: ;
			endcase
		endfunction

		function void note_pixel(logic fs, logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
			logic [PIX_W-1:0] c2);
			int unsigned     eff_w;
			int unsigned     eff_h;
			int unsigned     col;
			int unsigned     row;
			logic [23:0]     pix;
			logic [23:0]     win [3][3];
			longint unsigned mid_val;
			longint unsigned side_sum;
			longint unsigned diag_sum;
			longint unsigned acc;
			filt_res_t       r;
			bit              inner;

			eff_w = (width_reg == 0) ? 1 : width_reg;
			if (eff_w > DEF_MAX_WIDTH) eff_w = DEF_MAX_WIDTH;
			eff_h = (height_reg == 0) ? 1 : height_reg;
			if (eff_h > MAX_HEIGHT) eff_h = MAX_HEIGHT;

			if (fs) begin
				col_pos = 0;
				row_pos = 0;
			end
			if (col_pos >= eff_w) col_pos = 0;
			if (row_pos >= eff_h) row_pos = 0;
			col = col_pos;
			row = row_pos;

			pix = {c2, c1, c0};
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win_cells[i];
				win[i][1] = win_cells[3 + i];
			end
			win[0][2] = prev_prev_line[col];
			win[1][2] = prev_line[col];
			win[2][2] = pix;

			if (col >= 1 && row >= 1) begin
				inner = (col >= 2 && row >= 2);
				for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
					if (inner && ch < DEF_CHANNELS) begin
						mid_val  = win[1][1][8*ch +: 8];
						side_sum = win[0][1][8*ch +: 8];
						side_sum = side_sum + win[2][1][8*ch +: 8] + win[1][0][8*ch +: 8]
							+ win[1][2][8*ch +: 8];
						diag_sum = win[0][0][8*ch +: 8];
						diag_sum = diag_sum + win[0][2][8*ch +: 8] + win[2][0][8*ch +: 8]
							+ win[2][2][8*ch +: 8];
						acc = (mid_val * wt_center + side_sum * wt_side + diag_sum * wt_diag) >> 16;
						r.outs[ch] = (acc > 255) ? 8'hFF : acc[7:0];
					end else begin
						r.outs[ch] = '0;
					end
				end
				r.col      = COL_W'(col - 1);
				r.row      = ROW_W'(row - 1);
				r.interior = inner;
				expected_q.push_back(r);
			end

			for (int i = 0; i < 3; i++) begin
				win_cells[i]     = win_cells[3 + i];
				win_cells[3 + i] = win[i][2];
			end
			prev_prev_line[col] = win[1][2];
			prev_line[col]      = pix;

			col_pos = col + 1;
			if (col_pos >= eff_w) begin
				col_pos = 0;
				row_pos = row + 1;
				if (row_pos >= eff_h) row_pos = 0;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [PIX_W-1:0] o0, logic [PIX_W-1:0] o1,
			logic [PIX_W-1:0] o2, logic [COL_W-1:0] col, logic [ROW_W-1:0] row, logic inter);
			filt_res_t e;

			if (expected_q.size() == 0) begin
				mismatches++;
				$display("%0t ns: result with none expected, expected nothing, actual col %0d row %0d",
					$time, col, row);
				return;
			end
			e = expected_q.pop_front();
			results_seen++;
			if (e.interior) interior_seen++;
			compare_field("out0", e.outs[0], o0);
			compare_field("out1", e.outs[1], o1);
			compare_field("out2", e.outs[2], o2);
			compare_field("center_col", e.col, col);
			compare_field("center_row", e.row, row);
			compare_field("interior", e.interior, inter);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	conv3_pix_if pix_ch ();
	conv3_res_if res_ch ();

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned pixels_sent    = 0;
	int unsigned settings_run   = 0;
	int unsigned holds_done     = 0;
	int unsigned cycle_count    = 0;

	filter_scoreboard sb;

	conv3x3_image_filter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_ch),
		.res       (res_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Receiver: drop ready at random on the falling edge, at the current stall rate.
	always @(negedge clk) begin
		res_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Sample both channels at the rising edge: note each pixel transfer first,
	// then check any result transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (pix_ch.valid && pix_ch.ready)
				sb.note_pixel(pix_ch.frame_start, pix_ch.chan0, pix_ch.chan1, pix_ch.chan2);
			if (res_ch.valid === 1'b1 && res_ch.ready)
				sb.check_result(res_ch.out0, res_ch.out1, res_ch.out2,
					res_ch.center_col, res_ch.center_row, res_ch.interior);
		end
	end

	// Watchdog: end the run if it drags on far beyond any correct run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still awaited",
				cycle_count, sb.pending());
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [PIX_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
		0:       return '0;
		1:       return '1;
		default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Weights up to one eighth most often, with zero, one, the register maximum
	// and anything in between mixed in.
	function automatic logic [CFG_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
		0:       return '0;
		1:       return UNITY_WEIGHT;
		2:       return '1;
		5:       return CFG_W'($urandom_range(0, 2**CFG_W - 1));
		default: return CFG_W'($urandom_range(0, 8192));
		endcase
	endfunction

	// Drive one pixel from the falling edge, with random idle cycles first,
	// and hold it until its transfer.
	task automatic push_pixel(logic fs, logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
		logic [PIX_W-1:0] c2);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_ch.valid = 1'b0;
			@(negedge clk);
		end
		pix_ch.valid       = 1'b1;
		pix_ch.frame_start = fs;
		pix_ch.chan0       = c0;
		pix_ch.chan1       = c1;
		pix_ch.chan2       = c2;
		pixels_sent++;
		do @(posedge clk); while (pix_ch.ready !== 1'b1);
	endtask

	// Stop sending, wait for every awaited result, then let the pipeline empty:
	// pixels in a first row or column leave work in flight with nothing awaited.
	task automatic settle();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_wen   = 1'b0;
	endtask

	task automatic configure(logic [IMG_W_W-1:0] w, logic [IMG_H_W-1:0] h,
		logic [CFG_W-1:0] wc, logic [CFG_W-1:0] ws, logic [CFG_W-1:0] wd);
		write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
		write_reg(REG_WEIGHT_CENTER, wc);
		write_reg(REG_WEIGHT_EDGE, ws);
		write_reg(REG_WEIGHT_CORNER, wd);
		settings_run++;
	endtask

	// Raster stream of random pixels opened by a frame start. With noise, a stray
	// frame start now and then cuts a frame short. Now and then, or when forced,
	// hold the sender mid-stream until everything awaited has come back.
	task automatic random_phase(int n_pix, bit noise, bit force_hold);
		int   hold_at;
		logic fs;

		hold_at = -1;
		if (force_hold || $urandom_range(0, 3) == 0) hold_at = $urandom_range(1, n_pix - 1);
		for (int k = 0; k < n_pix; k++) begin
			if (k == hold_at) begin
				settle();
				holds_done++;
			end
			fs = (k == 0) || (noise && $urandom_range(0, 99) == 0);
			push_pixel(fs, rand_sample(), rand_sample(), rand_sample());
		end
	endtask

	initial begin
		int unsigned        seg_start;
		logic [IMG_W_W-1:0] w;
		logic [IMG_H_W-1:0] h;

		sb                 = new();
		arst_n             = 1'b0;
		cfg_wen            = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		pix_ch.valid       = 1'b0;
		pix_ch.frame_start = 1'b0;
		pix_ch.chan0       = '0;
		pix_ch.chan1       = '0;
		pix_ch.chan2       = '0;
		res_ch.ready       = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part runs under light sender idling and heavy receiver stalls.
		send_idle_pct  = 14;
		recv_stall_pct = 56;

		// Smallest frame with a pass-through kernel: the one interior result must
		// return the centre pixel unchanged; the other three are border results.
		configure(3, 3, UNITY_WEIGHT, '0, '0);
		push_pixel(1'b1, 8'h00, 8'hFF, 8'h55);
		push_pixel(1'b0, 8'hFF, 8'h00, 8'hAA);
		push_pixel(1'b0, 8'h80, 8'h7F, 8'h01);
		push_pixel(1'b0, 8'h01, 8'hFE, 8'h80);
		push_pixel(1'b0, 8'hFF, 8'h00, 8'h5A);
		push_pixel(1'b0, 8'h7F, 8'h80, 8'hFE);
		push_pixel(1'b0, 8'hAA, 8'h55, 8'hFF);
		push_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
		push_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
		settle();

		// Weights just below one and near two: channel 0 saturates, channel 1 sees only the
		// zero centre weight, channel 2 sums small values. The tenth pixel wraps
		// the frame and must give nothing.
		configure(3, 3, '0, CFG_W'(65535), '1);
		for (int i = 0; i < 10; i++)
			push_pixel(i == 0, (i == 4) ? 8'h00 : 8'hFF, (i == 4) ? 8'hFF : 8'h00, 8'h01);
		settle();

		// Zero width and height clamp to one: no pixel may produce a result.
		configure('0, '0, UNITY_WEIGHT, UNITY_WEIGHT, UNITY_WEIGHT);
		push_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(1'b0, 8'h00, 8'h00, 8'h00);
		push_pixel(1'b1, 8'hFF, 8'h00, 8'hFF);
		push_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
		settle();

		// Random part in three stretches: sender light and receiver heavy, then
		// the other way round, then neither idling. Each setting opens a frame.
		for (int seg = 0; seg < 3; seg++) begin
			case (seg)
			0: begin
				send_idle_pct  = 14;
				recv_stall_pct = 56;
			end
			1: begin
				send_idle_pct  = 56;
				recv_stall_pct = 14;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			endcase
			seg_start = pixels_sent;
			while (pixels_sent - seg_start < RANDOM_PIXELS / 3) begin
				case ($urandom_range(0, 9))
				0:       w = IMG_W_W'($urandom_range(0, 2));
				1:       w = IMG_W_W'($urandom_range(DEF_MAX_WIDTH + 1, 2**IMG_W_W - 1));
				default: w = IMG_W_W'($urandom_range(3, 16));
				endcase
				case ($urandom_range(0, 9))
				0:       h = IMG_H_W'($urandom_range(0, 1));
				1:       h = IMG_H_W'($urandom_range(MAX_HEIGHT, 2**IMG_H_W - 1));
				default: h = IMG_H_W'($urandom_range(2, 8));
				endcase
				configure(w, h, pick_weight(), pick_weight(), pick_weight());
				// Writes to an undecoded index must leave every register alone.
				if ($urandom_range(0, 7) == 0)
					write_reg(REG_SPARE, CFG_W'($urandom_range(0, 2**CFG_W - 1)));
				random_phase($urandom_range(30, 140), 1'b1, holds_done == 0);
				settle();
			end
		end

		$display("Run covered %0d pixels over %0d register settings, %0d sender holds.",
			pixels_sent, settings_run, holds_done);
		$display("Checked %0d results, %0d of them interior, %0d mismatches.",
			sb.results_seen, sb.interior_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
